// File: rtl/b2da_pkg.sv
package b2da_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_BITS = 4;
    localparam int BCD_BITS = NUM_DIGITS * DIGIT_BITS;
    localparam int DIGIT_IDX_W = 4;
    localparam int CHAR_WIDTH = 6;
    localparam int STEPS_PER_STAGE = 4;

    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;
    localparam logic [CHAR_WIDTH-1:0] ASCII_NINE = 6'd57;
    localparam logic [DIGIT_BITS-1:0] DIGIT_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_BITS-1:0] DIGIT_ADJ = 4'd3;

    typedef logic [BCD_BITS-1:0] t_bcd;
    typedef logic [DIGIT_IDX_W-1:0] t_digit_idx;

    // one shift-add-3 step: adjust every digit of five or more, then shift in the next bit
    function automatic t_bcd dd_step(input t_bcd bcd, input logic bit_in);
        t_bcd adj;
        adj = bcd;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (adj[DIGIT_BITS*i +: DIGIT_BITS] >= DIGIT_ADJ_MIN) begin
                adj[DIGIT_BITS*i +: DIGIT_BITS] = adj[DIGIT_BITS*i +: DIGIT_BITS] + DIGIT_ADJ;
            end
        end
        return {adj[BCD_BITS-2:0], bit_in};
    endfunction

endpackage

// File: rtl/binary_to_decimal_ascii_unit.sv
// an accepted word passes the input register, the conversion stages, the normalise register and
// the output register before its first digit shows; the shift-add-3 pass runs four steps per pipeline stage
// throughput: a new word can enter every cycle while o_stall is low; each word then holds the single output
// register until all of its digits (1 to 10) are emitted, which sets the sustained rate
// reset (synchronous, active low) clears every valid bit; data registers are not reset
module binary_to_decimal_ascii_unit
    import b2da_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CHAR_WIDTH-1:0] o_digit_char,
    output logic                  o_last_digit
);

    localparam int CONV_BITS = (VALUE_BITS < VALUE_WIDTH) ? VALUE_BITS : VALUE_WIDTH;
    localparam int NUM_STAGES = (CONV_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // conversion pipeline; stage 0 is the input register
    logic                 r_vld [0:NUM_STAGES];
    logic [CONV_BITS-1:0] r_bin [0:NUM_STAGES];
    t_bcd                 r_bcd [1:NUM_STAGES];

    // normalise stage: digits left aligned, digit count minus one
    logic       r_nrm_vld;
    t_bcd       r_nrm_digits;
    t_digit_idx r_nrm_left;
    t_bcd       n_nrm_digits;
    t_digit_idx n_nrm_left;

    // output emitter
    logic       r_out_vld;
    t_bcd       r_out_digits;
    t_digit_idx r_out_left;
    logic       n_out_vld;
    t_bcd       n_out_digits;
    t_digit_idx n_out_left;

    logic load_ok;
    logic adv;

    assign load_ok = !r_out_vld || (!i_stall && (r_out_left == '0));
    assign adv = !r_nrm_vld || load_ok;
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_valid;
        end
        if (adv) begin
            r_bin[0] <= i_value[CONV_BITS-1:0];
        end
    end

    for (genvar s = 1; s <= NUM_STAGES; s++) begin : g_stage
        localparam int FIRST = (s - 1) * STEPS_PER_STAGE;
        t_bcd                 n_bcd;
        logic [CONV_BITS-1:0] n_bin;

        always_comb begin
            n_bin = r_bin[s-1];
            n_bcd = '0;
            if (s > 1) begin
                n_bcd = r_bcd[(s > 1) ? s - 1 : 1];
            end
            for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                if (FIRST + k < CONV_BITS) begin
                    n_bcd = dd_step(n_bcd, n_bin[CONV_BITS-1]);
                    n_bin = n_bin << 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (adv) begin
                r_vld[s] <= r_vld[s-1];
            end
            if (adv) begin
                r_bcd[s] <= n_bcd;
                r_bin[s] <= n_bin;
            end
        end
    end

    // find the most significant non-zero digit; zero keeps one digit
    always_comb begin
        t_digit_idx msd;
        t_digit_idx shamt;
        msd = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[NUM_STAGES][DIGIT_BITS*i +: DIGIT_BITS] != '0) begin
                msd = DIGIT_IDX_W'(i);
            end
        end
        shamt = DIGIT_IDX_W'(NUM_DIGITS - 1) - msd;
        n_nrm_digits = r_bcd[NUM_STAGES] << {shamt, 2'b00};
        n_nrm_left = msd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nrm_vld <= 1'b0;
        end else if (adv) begin
            r_nrm_vld <= r_vld[NUM_STAGES];
        end
        if (adv) begin
            r_nrm_digits <= n_nrm_digits;
            r_nrm_left <= n_nrm_left;
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        n_out_digits = r_out_digits;
        n_out_left = r_out_left;
        if (load_ok) begin
            n_out_vld = r_nrm_vld;
            n_out_digits = r_nrm_digits;
            n_out_left = r_nrm_left;
        end else if (!i_stall) begin
            n_out_digits = r_out_digits << DIGIT_BITS;
            n_out_left = r_out_left - DIGIT_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
        r_out_digits <= n_out_digits;
        r_out_left <= n_out_left;
    end

    assign o_valid = r_out_vld;
    assign o_digit_char = ASCII_ZERO + {2'b00, r_out_digits[BCD_BITS-1 -: DIGIT_BITS]};
    assign o_last_digit = (r_out_left == '0);

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (o_digit_char >= ASCII_ZERO && o_digit_char <= ASCII_NINE))
        else $error("digit character out of range");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_stall && (r_out_left != '0) |=> r_out_vld)
        else $error("digit run ended early");

    a_nrm_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nrm_vld && !adv |=> r_nrm_vld && $stable(r_nrm_digits) && $stable(r_nrm_left))
        else $error("waiting word lost in normalise stage");

    a_count_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nrm_vld |-> (r_nrm_left < DIGIT_IDX_W'(NUM_DIGITS)))
        else $error("digit count too large");

endmodule

// File: dv/tb.sv
module tb
    import b2da_pkg::*;
();

    localparam int RANDOM_WORDS = 250;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] ch;
        logic                  last;
    } t_digit;

    class digit_scoreboard;
        t_digit expected_digits[$];
        int     errors;

        function new();
            errors = 0;
        endfunction

        // decimal text of one accepted word, most significant digit first
        function void note_value(logic [VALUE_WIDTH-1:0] value);
            logic [CHAR_WIDTH-1:0] chars[$];
            logic [VALUE_WIDTH-1:0] rest;
            logic [DIGIT_BITS-1:0]  d;
            t_digit                 item;
            rest = value;
            do begin
                d = DIGIT_BITS'(rest % 10);
                chars.push_front(ASCII_ZERO + CHAR_WIDTH'(d));
                rest = rest / 10;
            end while (rest != 0);
            foreach (chars[k]) begin
                item.ch   = chars[k];
                item.last = (k == chars.size() - 1);
                expected_digits.push_back(item);
            end
        endfunction

        function void check_digit(logic [CHAR_WIDTH-1:0] ch, logic last);
            t_digit want;
            if (expected_digits.size() == 0) begin
                $display("%0t: unexpected digit, got char %0d last %0b", $time, ch, last);
                errors++;
                return;
            end
            want = expected_digits.pop_front();
            if (ch !== want.ch) begin
                $display("%0t: digit_char mismatch, expected %0d, got %0d",
                         $time, want.ch, ch);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last_digit mismatch, expected %0b, got %0b",
                         $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic [VALUE_WIDTH-1:0] i_value;
    logic                   o_valid;
    logic                   i_stall;
    logic [CHAR_WIDTH-1:0]  o_digit_char;
    logic                   o_last_digit;

    digit_scoreboard sb;
    bit              no_idle;
    int              sent_count;
    int              cycles;

    binary_to_decimal_ascii_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_digit(o_digit_char, o_last_digit);
        end
    end

    // receiver: random stalls outside the no-idle stretch, one long hold-off once sixty words have been sent
    initial begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (!held && sent_count >= 60) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_stall   <= 1'b1;
            end else if (no_idle) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < 22);
            end
        end
    end

    task automatic send_value(logic [VALUE_WIDTH-1:0] value);
        while (!no_idle && $urandom_range(0, 99) < 22) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            i_value <= $urandom;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        sb.note_value(value);
        sent_count++;
    endtask

    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        logic [VALUE_WIDTH-1:0] p;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom >> $urandom_range(0, 31);
            2: begin
                p = 1;
                repeat ($urandom_range(0, 9)) p = p * 10;
                return p + $urandom_range(0, 2) - 1;
            end
            default: return $urandom_range(0, 999);
        endcase
    endfunction

    initial begin
        logic [VALUE_WIDTH-1:0] directed[];
        directed = '{
            32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd4294967295,
            32'd4294967294, 32'd1000000000, 32'd999999999, 32'd2147483648,
            32'd2147483647, 32'h5555_5555, 32'hAAAA_AAAA, 32'd4000000000,
            32'd12345, 32'd65536, 32'd500000000, 32'd1099999999, 32'd9999,
            32'd10000
        };
        sb         = new();
        cycles     = 0;
        sent_count = 0;
        no_idle    = 1'b0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_value    = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) send_value(directed[k]);
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // a stretch with both sides running flat out
            no_idle = (n >= 150 && n < 210);
            send_value(pick_value());
        end
        no_idle = 1'b0;
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (sb.expected_digits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_digits.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/b2da_pkg.sv
rtl/binary_to_decimal_ascii_unit.sv
dv/tb.sv
